// ===== rtl/b64d_pkg.sv =====
package b64d_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int OBDEPTH = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [1:0] ST_CONT = 2'd0;
	localparam logic [1:0] ST_OK = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	typedef struct packed {
		logic [7:0] in_char;
		logic has_char;
		logic end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic byte_valid;
		logic [1:0] status;
		logic string_done;
	} out_item_t;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_DATA,
		CLS_PAD,
		CLS_BAD
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic [5:0] value;
		logic eos;
	} token_t;

	typedef enum logic [1:0] {
		PH_RUN,
		PH_PAD,
		PH_ERR
	} phase_t;

endpackage

// ===== rtl/b64d_front.sv =====
module b64d_front import b64d_pkg::*; (
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	input  logic     q_full,
	output logic     q_push,
	output token_t   q_data
);

	always_comb begin
		q_data.cls = CLS_NONE;
		q_data.value = '0;
		q_data.eos = item.end_of_string;
		if (item.has_char) begin
			case (item.in_char) inside
				[8'h41:8'h5A]: begin
					q_data.cls = CLS_DATA;
					q_data.value = 6'(item.in_char - 8'h41);
				end
				[8'h61:8'h7A]: begin
					q_data.cls = CLS_DATA;
					q_data.value = 6'(item.in_char - 8'h47);
				end
				[8'h30:8'h39]: begin
					q_data.cls = CLS_DATA;
					q_data.value = 6'(item.in_char + 8'h04);
				end
				8'h2D: begin
					q_data.cls = CLS_DATA;
					q_data.value = 6'd62;
				end
				8'h5F: begin
					q_data.cls = CLS_DATA;
					q_data.value = 6'd63;
				end
				PAD_CHAR: begin
					q_data.cls = CLS_PAD;
				end
				default: begin
					q_data.cls = CLS_BAD;
				end
			endcase
		end
	end

	// Requests with neither a character nor an end mark have no effect and are dropped here.
	assign q_push = push && !q_full && (item.has_char || item.end_of_string);
	assign full = q_full;

endmodule

// ===== rtl/b64d_queue.sv =====
module b64d_queue import b64d_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  token_t wr_data,
	output logic   q_full,
	input  logic   rd_en,
	output logic   q_empty,
	output token_t rd_data
);

	token_t mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0] cnt_q;

	assign q_full = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
		end
	end

endmodule

// ===== rtl/b64d_back.sv =====
module b64d_back import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  token_t    tok,
	output logic      q_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic [5:0] rem_q;
	logic [2:0] cnt_q;
	phase_t phase_q;

	out_item_t ob_q [OBDEPTH];
	logic ob_wr_q;
	logic ob_rd_q;
	logic [1:0] ob_cnt_q;

	logic take;
	logic [11:0] acc;
	logic [2:0] sh;
	logic got_byte;
	logic [7:0] dec_byte;
	logic [5:0] rem_d;
	logic [2:0] cnt_d;
	phase_t phase_d;
	logic res_push;
	logic res_pop;
	out_item_t res_d;

	assign take = !q_empty && (ob_cnt_q != 2'(OBDEPTH));
	assign q_pop = take;

	always_comb begin
		acc = {rem_q, tok.value};
		sh = cnt_q - 3'd2;
		got_byte = 1'b0;
		dec_byte = '0;
		rem_d = rem_q;
		cnt_d = cnt_q;
		phase_d = phase_q;
		if (phase_q == PH_RUN) begin
			case (tok.cls)
				CLS_DATA: begin
					if (cnt_q >= 3'd2) begin
						got_byte = 1'b1;
						dec_byte = 8'(acc >> sh);
						rem_d = 6'(acc & ((12'd1 << sh) - 12'd1));
						cnt_d = sh;
					end else begin
						rem_d = tok.value;
						cnt_d = 3'd6;
					end
				end
				CLS_PAD: phase_d = PH_PAD;
				CLS_BAD: phase_d = PH_ERR;
				default: ;
			endcase
		end
		res_d.out_byte = dec_byte;
		res_d.byte_valid = got_byte;
		res_d.string_done = tok.eos;
		res_d.status = ST_CONT;
		if (tok.eos) begin
			res_d.status = (phase_d == PH_RUN || phase_d == PH_PAD) ? ST_OK : ST_FAIL;
			rem_d = '0;
			cnt_d = '0;
			phase_d = PH_RUN;
		end
	end

	assign res_push = take && (got_byte || tok.eos);
	assign res_pop = pop && (ob_cnt_q != '0);
	assign empty = (ob_cnt_q == '0);
	assign result = ob_q[ob_rd_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			ob_q[ob_wr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			cnt_q <= '0;
			phase_q <= PH_RUN;
			ob_wr_q <= 1'b0;
			ob_rd_q <= 1'b0;
			ob_cnt_q <= '0;
		end else begin
			if (take) begin
				rem_q <= rem_d;
				cnt_q <= cnt_d;
				phase_q <= phase_d;
			end
			if (res_push) begin
				ob_wr_q <= !ob_wr_q;
			end
			if (res_pop) begin
				ob_rd_q <= !ob_rd_q;
			end
			ob_cnt_q <= ob_cnt_q + 2'(res_push) - 2'(res_pop);
		end
	end

	a_cnt_even: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] == 1'b0 && ob_cnt_q <= 2'(OBDEPTH))
		else $error("bit count odd or result buffer overrun");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && tok.eos |=> cnt_q == '0 && rem_q == '0 && phase_q == PH_RUN)
		else $error("state not cleared after end of string");

	a_no_byte_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q != PH_RUN |-> !got_byte)
		else $error("byte emitted after pad or error");

endmodule

// ===== rtl/base64url_decoder.sv =====
// Streaming base64url decoder. Each request carries at most one character and may close the
// current string; a request with neither is accepted and dropped. Requests enter a four-entry
// queue, so one request is accepted every cycle while the queue has room, and the decode stage
// consumes one queued request per cycle while its two-entry result buffer has room, giving a
// sustained rate of one character per clock while results are popped. Each result is written
// into the result buffer and waits there until popped. A result carries a byte, the end status
// of the string, or both. After an invalid character no more bytes are produced for that string
// and its closing result reports the failure; bytes already delivered for a failed string must
// be discarded downstream. After a pad character the rest of the string is ignored. Leftover
// bits at the end of a string are dropped.
module base64url_decoder import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	token_t q_wr_data;
	token_t q_rd_data;

	b64d_front u_front (
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wr_data)
	);

	b64d_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_empty (q_empty),
		.rd_data (q_rd_data)
	);

	b64d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.tok     (q_rd_data),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
